FILE: rtl/lcd_controller_bus_emulator_macros.svh
// Assertion macros shared by the checker of the LCD controller bus emulator.
`ifndef LCD_CONTROLLER_BUS_EMULATOR_MACROS_SVH
`define LCD_CONTROLLER_BUS_EMULATOR_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define LCDBE_CHECK(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed: label");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define LCDBE_CHECK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed: label");

`endif

FILE: rtl/lcdbe_pkg.sv
// Types and constants of the LCD controller bus emulator.
`timescale 1ns / 1ps

package lcdbe_pkg;

	localparam logic [1:0] OP_DATA  = 2'd0;
	localparam logic [1:0] OP_CMD   = 2'd1;
	localparam logic [1:0] OP_PIXEL = 2'd2;

	localparam logic [7:0] CMD_SET_ADDRESS  = 8'h24;
	localparam logic [7:0] CMD_TEXT_AREA    = 8'h41;
	localparam logic [7:0] CMD_GRAPHIC_AREA = 8'h43;
	localparam logic [7:0] CMD_AUTO_START   = 8'hB0;
	localparam logic [7:0] CMD_AUTO_END     = 8'hB2;

	localparam logic [5:0] RESET_COLUMNS = 6'd30;

	localparam int VALUE_W = 16;
	localparam int RECIP_W = 18;
	localparam int PROD_W  = VALUE_W + RECIP_W;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] bus_byte;
		logic [7:0] pixel_x;
		logic [7:0] pixel_y;
	} req_t;

	typedef struct packed {
		logic        pixel_white;
		logic [5:0]  columns_in_use;
		logic        auto_write_on;
		logic [15:0] address_now;
	} rsp_t;

endpackage

FILE: rtl/lcdbe_mod_unit.sv
// Remainder unit: reduces a 16-bit value modulo a constant by reciprocal multiplication.
`timescale 1ns / 1ps

module lcdbe_mod_unit #(
	parameter int MODULUS = 2048
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  logic [lcdbe_pkg::VALUE_W-1:0]  value,
	output logic                           done,
	output logic [lcdbe_pkg::VALUE_W-1:0]  rem
);

	// The reciprocal is rounded up, which makes the quotient exact for every 16-bit value.
	localparam int SHIFT = lcdbe_pkg::VALUE_W + $clog2(MODULUS);
	localparam logic [63:0] RECIP_L = ((64'd1 << SHIFT) + 64'(MODULUS) - 64'd1) / 64'(MODULUS);
	localparam logic [lcdbe_pkg::RECIP_W-1:0] RECIP = lcdbe_pkg::RECIP_W'(RECIP_L);
	localparam logic [lcdbe_pkg::VALUE_W-1:0] MOD_V = lcdbe_pkg::VALUE_W'(MODULUS);

	logic                            run_s1;
	logic                            run_s2;
	logic                            done_s3;
	logic [lcdbe_pkg::VALUE_W-1:0]   value_s1;
	logic [lcdbe_pkg::VALUE_W-1:0]   quot_s2;
	logic [lcdbe_pkg::VALUE_W-1:0]   rem_s3;
	logic [lcdbe_pkg::PROD_W-1:0]    prod;
	logic [lcdbe_pkg::VALUE_W-1:0]   quot;
	logic [lcdbe_pkg::VALUE_W-1:0]   back;

	assign prod = lcdbe_pkg::PROD_W'(value_s1) * lcdbe_pkg::PROD_W'(RECIP);
	assign quot = lcdbe_pkg::VALUE_W'(prod >> SHIFT);
	assign back = quot_s2 * MOD_V;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_s1  <= 1'b0;
			run_s2  <= 1'b0;
			done_s3 <= 1'b0;
		end else begin
			run_s1  <= load;
			run_s2  <= run_s1;
			done_s3 <= run_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_s1 <= value;
		end
		if (run_s1) begin
			quot_s2 <= quot;
		end
		if (run_s2) begin
			rem_s3 <= value_s1 - back;
		end
	end

	assign done = done_s3;
	assign rem  = rem_s3;

endmodule

FILE: rtl/lcd_controller_bus_emulator.sv
// Top level of the LCD controller bus emulator: parameter stack, address pointer and frame store.
// Data bytes outside auto-write, commands and pixels outside the image strobe done in the cycle
// after start is taken; an auto-write byte first passes the pipelined remainder unit, and an
// in-image pixel read passes it and then the registered read of the frame store.
// A new request is taken in the cycle its predecessor's result shows; done cannot be held off.
// After reset the frame store is cleared one byte a cycle, with busy high until the last byte is written.
`timescale 1ns / 1ps

module lcd_controller_bus_emulator #(
	parameter int BUFFER_BYTES   = 2048,
	parameter int MAX_COLUMNS    = 32,
	parameter int DISPLAY_HEIGHT = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  lcdbe_pkg::req_t   cmd,
	output logic              done,
	output lcdbe_pkg::rsp_t   rsp
);

	localparam int AW = $clog2(BUFFER_BYTES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(BUFFER_BYTES - 1);
	localparam logic [16:0]   BUF_L     = 17'(BUFFER_BYTES);
	localparam logic [9:0]    MAXC_W    = 10'(MAX_COLUMNS);
	localparam logic [5:0]    MAXC      = 6'(MAX_COLUMNS);
	localparam logic [8:0]    HEIGHT_L  = 9'(DISPLAY_HEIGHT);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_MOD   = 4'b0100,
		ST_READ  = 4'b1000
	} state_t;

	state_t       state_q;
	logic [AW-1:0] clr_q;
	logic [7:0]   stack0_q;
	logic [7:0]   stack1_q;
	logic [15:0]  ptr_q;
	logic         auto_q;
	logic [5:0]   cols_q;
	logic         done_q;
	logic         white_q;
	logic         write_q;
	logic [7:0]   byte_q;
	logic [2:0]   bit_q;
	logic [7:0]   rdata_q;
	logic [7:0]   mem [BUFFER_BYTES];

	logic         accept;
	logic         mod_load;
	logic [15:0]  mod_value;
	logic         mod_done;
	logic [15:0]  mod_rem;
	logic         pix_outside;
	logic [15:0]  pix_offset;
	logic [16:0]  ptr_next;
	logic [5:0]   cols_from_stack;
	logic [5:0]   cols_from_ptr;
	logic         mem_we;
	logic         mem_re;
	logic [AW-1:0] mem_addr;
	logic [7:0]   mem_wdata;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign pix_outside = ({1'b0, cmd.pixel_x} >= {cols_q, 3'b000})
		|| ({1'b0, cmd.pixel_y} >= HEIGHT_L);
	assign pix_offset = 16'(14'(cmd.pixel_y) * 14'(cols_q)) + 16'(cmd.pixel_x[7:3]);

	assign ptr_next = {1'b0, ptr_q} + 17'd1;

	assign cols_from_stack = (10'(stack1_q) < MAXC_W) ? stack1_q[5:0] : MAXC;
	assign cols_from_ptr   = (10'(ptr_q[15:6]) < MAXC_W) ? ptr_q[11:6] : MAXC;

	always_comb begin
		mod_load  = 1'b0;
		mod_value = ptr_q;
		if (accept) begin
			case (cmd.opcode)
				lcdbe_pkg::OP_DATA: begin
					mod_load = auto_q;
				end
				lcdbe_pkg::OP_PIXEL: begin
					mod_load  = !pix_outside;
					mod_value = pix_offset;
				end
				default: begin
					mod_load = 1'b0;
				end
			endcase
		end
	end

	lcdbe_mod_unit #(
		.MODULUS (BUFFER_BYTES)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (mod_load),
		.value  (mod_value),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	assign mem_we    = (state_q == ST_CLEAR) || (state_q == ST_MOD && mod_done && write_q);
	assign mem_re    = (state_q == ST_MOD) && mod_done && !write_q;
	assign mem_addr  = (state_q == ST_CLEAR) ? clr_q : mod_rem[AW-1:0];
	assign mem_wdata = (state_q == ST_CLEAR) ? 8'h00 : byte_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rdata_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q  <= cmd.bus_byte;
			bit_q   <= cmd.pixel_x[2:0];
			write_q <= (cmd.opcode == lcdbe_pkg::OP_DATA);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			stack0_q <= 8'h00;
			stack1_q <= 8'h00;
			ptr_q    <= 16'h0000;
			auto_q   <= 1'b0;
			cols_q   <= lcdbe_pkg::RESET_COLUMNS;
			done_q   <= 1'b0;
			white_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						white_q <= 1'b0;
						case (cmd.opcode)
							lcdbe_pkg::OP_DATA: begin
								if (auto_q) begin
									state_q <= ST_MOD;
								end else begin
									stack1_q <= stack0_q;
									stack0_q <= cmd.bus_byte;
									done_q   <= 1'b1;
								end
							end
							lcdbe_pkg::OP_CMD: begin
								done_q <= 1'b1;
								case (cmd.bus_byte)
									lcdbe_pkg::CMD_SET_ADDRESS: begin
										ptr_q <= {stack0_q, stack1_q};
									end
									lcdbe_pkg::CMD_TEXT_AREA, lcdbe_pkg::CMD_GRAPHIC_AREA: begin
										cols_q <= cols_from_stack;
									end
									lcdbe_pkg::CMD_AUTO_START: begin
										auto_q <= 1'b1;
									end
									lcdbe_pkg::CMD_AUTO_END: begin
										auto_q <= 1'b0;
										cols_q <= cols_from_ptr;
									end
									default: begin
									end
								endcase
							end
							lcdbe_pkg::OP_PIXEL: begin
								if (pix_outside) begin
									done_q <= 1'b1;
								end else begin
									state_q <= ST_MOD;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						if (write_q) begin
							ptr_q   <= (ptr_next >= BUF_L) ? 16'h0000 : ptr_next[15:0];
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					white_q <= rdata_q[3'd7 - bit_q];
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done               = done_q;
	assign rsp.pixel_white    = white_q;
	assign rsp.columns_in_use = cols_q;
	assign rsp.auto_write_on  = auto_q;
	assign rsp.address_now    = ptr_q;

endmodule

FILE: rtl/lcdbe_checker.sv
// Port-level checker of the LCD controller bus emulator and its bind to the top level.
`timescale 1ns / 1ps
`include "lcd_controller_bus_emulator_macros.svh"

module lcdbe_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input lcdbe_pkg::req_t cmd,
	input logic            done,
	input lcdbe_pkg::rsp_t rsp
);

	logic [1:0] opcode_seen;

	assign opcode_seen = cmd.opcode;

	// A taken request either finishes at once or keeps the block busy.
	`LCDBE_CHECK_NEXT(a_accept_progress, start && !busy, busy || done)

	// A result only follows a taken request or a cycle of work.
	`LCDBE_CHECK(a_done_has_cause, done, $past(start || busy))

	// A white pixel needs a display at least one byte column wide.
	`LCDBE_CHECK(a_white_needs_width, done && rsp.pixel_white, rsp.columns_in_use != 6'd0)

	// With no request and no work the status stays put.
	`LCDBE_CHECK_NEXT(a_idle_stable, !busy && !start && (opcode_seen == opcode_seen),
		$stable(rsp.address_now) && $stable(rsp.columns_in_use) && $stable(rsp.auto_write_on))

endmodule

bind lcd_controller_bus_emulator lcdbe_checker u_checker (.*);

FILE: verif/lcd_controller_bus_emulator_test.sv
// Self-checking testbench of the LCD controller bus emulator with a predicting scoreboard.
`timescale 1ns / 1ps

module lcd_controller_bus_emulator_test;

	localparam int FRAME_BYTES  = 2048;
	localparam int COLUMN_LIMIT = 32;
	localparam int IMAGE_ROWS   = 64;
	localparam int COLUMN_SPAN  = 64;
	localparam int RANDOM_ITEMS = 1250;
	localparam int STALL_LIMIT  = 10000;

	localparam logic [1:0] OP_NONE       = 2'd3;
	localparam logic [7:0] CMD_UNDEFINED = 8'hFF;
	localparam logic [7:0] CMD_ZERO      = 8'h00;

	class lcd_status_board;
		lcdbe_pkg::rsp_t pending[$];
		int          mismatches;
		logic [7:0]  stack_top;
		logic [7:0]  stack_next;
		logic [15:0] address;
		logic        auto_on;
		logic [5:0]  columns;
		logic [7:0]  frame [FRAME_BYTES];

		function new();
			mismatches = 0;
			stack_top = 8'h00;
			stack_next = 8'h00;
			address = 16'h0000;
			auto_on = 1'b0;
			columns = lcdbe_pkg::RESET_COLUMNS;
			foreach (frame[i])
				frame[i] = 8'h00;
		endfunction

		function logic [5:0] limit_columns(int unsigned v);
			logic [5:0] c;
			if (v < COLUMN_LIMIT)
				c = 6'(v);
			else
				c = 6'(COLUMN_LIMIT);
			return c;
		endfunction

		function void note_request(lcdbe_pkg::req_t r);
			lcdbe_pkg::rsp_t s;
			int unsigned px;
			int unsigned py;
			int unsigned cols;
			int unsigned offset;
			int unsigned step;
			s = '0;
			px = r.pixel_x;
			py = r.pixel_y;
			cols = columns;
			case (r.opcode)
				lcdbe_pkg::OP_DATA: begin
					if (!auto_on) begin
						stack_next = stack_top;
						stack_top = r.bus_byte;
					end else begin
						frame[address % FRAME_BYTES] = r.bus_byte;
						step = address + 1;
						address = (step >= FRAME_BYTES) ? 16'h0000 : 16'(step);
					end
				end
				lcdbe_pkg::OP_CMD: begin
					case (r.bus_byte)
						lcdbe_pkg::CMD_SET_ADDRESS: address = {stack_top, stack_next};
						lcdbe_pkg::CMD_TEXT_AREA, lcdbe_pkg::CMD_GRAPHIC_AREA:
							columns = limit_columns(stack_next);
						lcdbe_pkg::CMD_AUTO_START: auto_on = 1'b1;
						lcdbe_pkg::CMD_AUTO_END: begin
							auto_on = 1'b0;
							columns = limit_columns(address / COLUMN_SPAN);
						end
						default: ;
					endcase
				end
				lcdbe_pkg::OP_PIXEL: begin
					if (px < cols * 8 && py < IMAGE_ROWS) begin
						offset = (py * cols + (px >> 3)) % FRAME_BYTES;
						s.pixel_white = frame[offset][7 - (px & 7)];
					end
				end
				default: ;
			endcase
			s.columns_in_use = columns;
			s.auto_write_on = auto_on;
			s.address_now = address;
			pending.push_back(s);
		endfunction

		task report(string msg);
			$display("ERROR at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_result(lcdbe_pkg::rsp_t got);
			lcdbe_pkg::rsp_t want;
			if (pending.size() == 0) begin
				report("result with no request outstanding");
				return;
			end
			want = pending.pop_front();
			if (got.pixel_white !== want.pixel_white)
				report($sformatf("pixel_white %0d, expected %0d", got.pixel_white,
					want.pixel_white));
			if (got.columns_in_use !== want.columns_in_use)
				report($sformatf("columns_in_use %0d, expected %0d", got.columns_in_use,
					want.columns_in_use));
			if (got.auto_write_on !== want.auto_write_on)
				report($sformatf("auto_write_on %0d, expected %0d", got.auto_write_on,
					want.auto_write_on));
			if (got.address_now !== want.address_now)
				report($sformatf("address_now %0h, expected %0h", got.address_now,
					want.address_now));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	lcdbe_pkg::req_t cmd;
	logic done;
	lcdbe_pkg::rsp_t rsp;

	lcd_status_board status_board;
	int unsigned     sent_items;
	int unsigned     burst_left;
	int unsigned     idle_cycles = 0;

	lcd_controller_bus_emulator #(
		.BUFFER_BYTES(FRAME_BYTES),
		.MAX_COLUMNS(COLUMN_LIMIT),
		.DISPLAY_HEIGHT(IMAGE_ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.rsp(rsp)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				status_board.check_result(rsp);
			if (start && !busy)
				status_board.note_request(cmd);
		end
	end

	always @(posedge clk) begin
		if ((arst_n && start && !busy) || done) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task pause(int unsigned n);
		repeat (n) begin
			@(negedge clk);
			start = 1'b0;
			cmd = lcdbe_pkg::req_t'(26'($urandom));
		end
	endtask

	task send(logic [1:0] op, logic [7:0] b, logic [7:0] x, logic [7:0] y);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0)
				pause($urandom_range(1, 12));
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		@(negedge clk);
		start = 1'b1;
		cmd.opcode = op;
		cmd.bus_byte = b;
		cmd.pixel_x = x;
		cmd.pixel_y = y;
		do
			@(posedge clk);
		while (busy);
		sent_items++;
	endtask

	task push_byte(logic [7:0] b);
		send(lcdbe_pkg::OP_DATA, b, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
	endtask

	task run_command(logic [7:0] c);
		send(lcdbe_pkg::OP_CMD, c, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
	endtask

	task read_pixel(logic [7:0] x, logic [7:0] y);
		send(lcdbe_pkg::OP_PIXEL, 8'($urandom_range(0, 255)), x, y);
	endtask

	task load_address(logic [15:0] a);
		push_byte(a[7:0]);
		push_byte(a[15:8]);
		run_command(lcdbe_pkg::CMD_SET_ADDRESS);
	endtask

	task random_address();
		if ($urandom_range(0, 7) == 0)
			load_address(16'($urandom_range(0, 65535)));
		else
			load_address(16'($urandom_range(0, FRAME_BYTES - 1)));
	endtask

	task random_auto_write();
		int unsigned n;
		n = $urandom_range(1, 24);
		random_address();
		run_command(lcdbe_pkg::CMD_AUTO_START);
		repeat (n)
			push_byte(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 7) != 0)
			run_command(lcdbe_pkg::CMD_AUTO_END);
	endtask

	task random_area();
		int unsigned pick;
		logic [7:0]  v;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			v = 8'd0;
		else if (pick == 1)
			v = 8'($urandom_range(COLUMN_LIMIT + 1, 255));
		else
			v = 8'($urandom_range(1, COLUMN_LIMIT));
		push_byte(v);
		push_byte(8'($urandom_range(0, 255)));
		run_command($urandom_range(0, 1) ? lcdbe_pkg::CMD_TEXT_AREA
			: lcdbe_pkg::CMD_GRAPHIC_AREA);
	endtask

	task random_pixels();
		int unsigned n;
		int unsigned width;
		n = $urandom_range(1, 8);
		repeat (n) begin
			width = status_board.columns * 8;
			if (width != 0 && $urandom_range(0, 4) != 0)
				read_pixel(8'($urandom_range(0, width - 1)),
					8'($urandom_range(0, IMAGE_ROWS - 1)));
			else
				read_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		end
	endtask

	task random_noise();
		send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
	endtask

	initial begin
		int unsigned pick;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		sent_items = 0;
		burst_left = 0;
		status_board = new();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// A freshly cleared store, a no-op opcode and unknown command bytes.
		read_pixel(8'd0, 8'd0);
		send(OP_NONE, 8'hFF, 8'hFF, 8'hFF);
		run_command(CMD_ZERO);
		run_command(CMD_UNDEFINED);
		// Auto-write at address zero, then an end that leaves no columns in use.
		load_address(16'h0000);
		run_command(lcdbe_pkg::CMD_AUTO_START);
		push_byte(8'hFF);
		push_byte(8'h80);
		run_command(lcdbe_pkg::CMD_AUTO_END);
		read_pixel(8'd0, 8'd0);
		// A column count beyond the maximum is clamped.
		push_byte(8'hFF);
		push_byte(8'h00);
		run_command(lcdbe_pkg::CMD_TEXT_AREA);
		read_pixel(8'd0, 8'd0);
		read_pixel(8'd8, 8'd0);
		read_pixel(8'd9, 8'd0);
		read_pixel(8'd255, 8'd0);
		read_pixel(8'd0, 8'd64);
		read_pixel(8'd255, 8'd255);
		// The pointer beyond the store wraps the write and then returns to zero.
		load_address(16'hFFFF);
		run_command(lcdbe_pkg::CMD_AUTO_START);
		push_byte(8'hA5);
		run_command(lcdbe_pkg::CMD_AUTO_END);
		push_byte(8'd31);
		push_byte(8'h00);
		run_command(lcdbe_pkg::CMD_GRAPHIC_AREA);
		read_pixel(8'd247, 8'd63);
		read_pixel(8'd248, 8'd63);

		while (sent_items < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 30)
				random_auto_write();
			else if (pick < 60)
				random_pixels();
			else if (pick < 75)
				random_area();
			else if (pick < 85)
				random_address();
			else
				random_noise();
		end

		@(negedge clk);
		start = 1'b0;
		while (status_board.pending.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (status_board.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
